// File: rtl/bb3g_pkg.sv
// Package for the 3x3 grayscale box blur: field widths, register codes, stage types.
`default_nettype none

package bb3g_pkg;

  // Field widths
  localparam int unsigned PixW = 8;
  localparam int unsigned ColW = 11;
  localparam int unsigned RowW = 12;
  localparam int unsigned CfgW = 12;
  localparam int unsigned SumW = 12;  // nine 8-bit pixels, at most 2295

  // Register reset values and the smallest frame size in use
  localparam logic [CfgW-1:0] WidthReset  = 12'd1920;
  localparam logic [CfgW-1:0] HeightReset = 12'd1080;
  localparam logic [CfgW-1:0] MinSize     = 12'd3;

  // floor(x / 9) == (x * 7282) >> 16 for every x up to 2295
  localparam int unsigned     RecipW     = 13;
  localparam logic [RecipW-1:0] Div9Recip = 13'd7282;
  localparam int unsigned     Div9Shift  = 16;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  // One pixel on its way from the input register to the result register
  typedef struct packed {
    logic [PixW-1:0] pixel;   // bottom pixel of the new window column
    logic [ColW-1:0] col;     // centre column of the window
    logic [RowW-1:0] row;     // centre row of the window
    logic            emit;    // window centre is interior
    logic            done;    // last interior result of the frame
  } s1_t;

endpackage : bb3g_pkg

`default_nettype wire

// File: rtl/bb3g_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
`default_nettype none

module bb3g_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2048,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : bb3g_ram

`default_nettype wire

// File: rtl/box_blur_3x3_gray_unit.sv
// Top level of the 3x3 box blur over a raster stream of 8-bit grayscale pixels.
//
// Input channel: one pixel per transaction (in_valid_i / in_stall_o), raster order.
// Output channel: one result per interior pixel (out_valid_o / out_stall_i) with the
// truncated mean of its 3x3 neighborhood, its column and row, and frame_done_o on
// the last interior result of the frame. Border pixels give no transaction.
// Configuration: cfg_we_i writes cfg_wdata_i to image_width (index 0) or
// image_height (index 1); write only while the block is idle.
// Throughput: one pixel per cycle while the output is not stalled, set by the single
// line-store RAM read and write port pair. Pipeline: an accepted pixel and its
// line-store read enter the input stage, then sum and divide go to the result register.
// Reset: counters, window and valid bits clear, registers take 1920 x 1080; the
// line store is not cleared and holds no valid bits.
// Stall: while out_stall_i holds a result, one more pixel is taken into the input
// stage, then in_stall_o rises until the result register is free.
`default_nettype none

module box_blur_3x3_gray_unit
  import bb3g_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  // configuration write port
  input  wire logic            cfg_we_i,
  input  wire logic            cfg_idx_i,
  input  wire logic [CfgW-1:0] cfg_wdata_i,
  // pixel input
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire logic [PixW-1:0] pixel_value_i,
  // result output
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic      [PixW-1:0] blurred_value_o,
  output logic      [ColW-1:0] centre_column_o,
  output logic      [RowW-1:0] centre_row_o,
  output logic                 frame_done_o
);

  localparam int unsigned AddrW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CmpW  = 13;  // holds MAX_WIDTH up to 4096
  localparam int unsigned ProdW = SumW + RecipW;

  // Configuration registers
  logic [CfgW-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Frame size in use: width clamped to 3..MAX_WIDTH, height raised to 3
  logic [CmpW-1:0] eff_w;
  logic [CfgW-1:0] eff_h;

  always_comb begin
    if (width_q < MinSize) begin
      eff_w = CmpW'(MinSize);
    end else if ({1'b0, width_q} > CmpW'(MAX_WIDTH)) begin
      eff_w = CmpW'(MAX_WIDTH);
    end else begin
      eff_w = {1'b0, width_q};
    end
    eff_h = (height_q < MinSize) ? MinSize : height_q;
  end

  // Handshake and pipeline control
  logic s1_valid_q, out_valid_q;
  logic accept, s1_adv, s1_fire;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;
  assign s1_fire    = s1_valid_q && s1_adv;

  // Position counters of the next input pixel
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic            last_col, last_row;

  assign last_col = (CmpW'(col_q) + CmpW'(1)) >= eff_w;
  assign last_row = (CmpW'(row_q) + CmpW'(1)) >= CmpW'(eff_h);

  always_comb begin
    col_d = col_q + ColW'(1);
    row_d = row_q;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + RowW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Line-store address: column, clamped to the last entry
  logic [CmpW-1:0]  idx_full;
  logic [AddrW-1:0] rd_addr;

  assign idx_full = (CmpW'(col_q) < CmpW'(MAX_WIDTH)) ? CmpW'(col_q) : CmpW'(MAX_WIDTH - 1);
  assign rd_addr  = idx_full[AddrW-1:0];

  // Input stage
  s1_t              s1_d, s1_q;
  logic [AddrW-1:0] s1_addr_q;

  always_comb begin
    s1_d.pixel = pixel_value_i;
    s1_d.col   = col_q - ColW'(1);
    s1_d.row   = row_q - RowW'(1);
    s1_d.emit  = (col_q >= ColW'(2)) && (row_q >= RowW'(2));
    s1_d.done  = last_col && last_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q      <= s1_d;
      s1_addr_q <= rd_addr;
    end
  end

  // Line store: upper byte two rows above, lower byte one row above
  logic [2*PixW-1:0] ls_rdata;
  logic [PixW-1:0]   top_px, mid_px;

  assign top_px = ls_rdata[2*PixW-1:PixW];
  assign mid_px = ls_rdata[PixW-1:0];

  bb3g_ram #(
    .Width (2 * PixW),
    .Depth (MAX_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (s1_fire),
    .waddr_i (s1_addr_q),
    .wdata_i ({mid_px, s1_q.pixel}),
    .re_i    (accept),
    .raddr_i (rd_addr),
    .rdata_o (ls_rdata)
  );

  // Window of the two earlier columns: [0] column c-2, [1] column c-1
  logic [PixW-1:0] win_q [2][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        win_q[0][k] <= '0;
        win_q[1][k] <= '0;
      end
    end else if (s1_fire) begin
      for (int k = 0; k < 3; k++) begin
        win_q[0][k] <= win_q[1][k];
      end
      win_q[1][0] <= top_px;
      win_q[1][1] <= mid_px;
      win_q[1][2] <= s1_q.pixel;
    end
  end

  // Nine-pixel sum and divide by 9 through the reciprocal
  logic [SumW-1:0]  sum;
  logic [ProdW-1:0] prod;
  logic [PixW-1:0]  mean;

  always_comb begin
    sum = SumW'(top_px) + SumW'(mid_px) + SumW'(s1_q.pixel)
        + SumW'(win_q[0][0]) + SumW'(win_q[0][1]) + SumW'(win_q[0][2])
        + SumW'(win_q[1][0]) + SumW'(win_q[1][1]) + SumW'(win_q[1][2]);
    prod = ProdW'(sum) * ProdW'(Div9Recip);
    mean = prod[Div9Shift +: PixW];
  end

  // Result register
  logic [PixW-1:0] blur_q;
  logic [ColW-1:0] ccol_q;
  logic [RowW-1:0] crow_q;
  logic            done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q && s1_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_q.emit) begin
      blur_q <= mean;
      ccol_q <= s1_q.col;
      crow_q <= s1_q.row;
      done_q <= s1_q.done;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign blurred_value_o = blur_q;
  assign centre_column_o = ccol_q;
  assign centre_row_o    = crow_q;
  assign frame_done_o    = done_q;

endmodule : box_blur_3x3_gray_unit

`default_nettype wire

// File: tb/sv/tb_box_blur_3x3_gray_unit.sv
// Self-checking testbench for the 3x3 grayscale box blur: directed frames, then random frames.
`default_nettype none

module tb_box_blur_3x3_gray_unit;
  import bb3g_pkg::*;

  localparam int unsigned MaxW         = 2048;
  localparam int unsigned BlurDiv      = 9;
  localparam int unsigned RandomPixels = 300;
  localparam int unsigned QuietTail    = 100;   // last random pixels run with no idling
  localparam int unsigned DrainCycles  = 4;     // input stage and result register plus margin
  localparam int unsigned DirLen       = 18;

  // One output transaction
  typedef struct packed {
    logic [PixW-1:0] mean;
    logic [ColW-1:0] col;
    logic [RowW-1:0] row;
    logic            done;
  } blur_res_t;

  // One directed stimulus row; res is used only where typed is set
  typedef struct packed {
    logic [PixW-1:0] pix;
    logic            typed;
    blur_res_t       res;
  } dir_row_t;

  // DUT signals
  logic            clk_i         = 1'b0;
  logic            rst_ni        = 1'b0;
  logic            cfg_we_i      = 1'b0;
  logic            cfg_idx_i     = 1'b0;
  logic [CfgW-1:0] cfg_wdata_i   = '0;
  logic            in_valid_i    = 1'b0;
  logic            in_stall_o;
  logic [PixW-1:0] pixel_value_i = '0;
  logic            out_valid_o;
  logic            out_stall_i   = 1'b0;
  logic [PixW-1:0] blurred_value_o;
  logic [ColW-1:0] centre_column_o;
  logic [RowW-1:0] centre_row_o;
  logic            frame_done_o;

  // Predictor state: registers, line stores, window and raster position
  logic [CfgW-1:0] cfg_width  = WidthReset;
  logic [CfgW-1:0] cfg_height = HeightReset;
  logic [PixW-1:0] row_above     [MaxW];
  logic [PixW-1:0] row_two_above [MaxW];
  logic [PixW-1:0] win_prev2 [3];   // column c-2: top, mid, bottom
  logic [PixW-1:0] win_prev1 [3];   // column c-1
  logic [ColW-1:0] col_cnt = '0;
  logic [RowW-1:0] row_cnt = '0;

  blur_res_t   pending_blurs [$];
  int unsigned mismatches = 0;
  bit          src_gaps   = 1'b0;
  bit          sink_gaps  = 1'b0;
  int unsigned stall_left = 0;
  dir_row_t    dir_table [DirLen];

  always #2 clk_i = ~clk_i;

  box_blur_3x3_gray_unit #(
    .MAX_WIDTH(MaxW)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_value_i  (pixel_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .blurred_value_o(blurred_value_o),
    .centre_column_o(centre_column_o),
    .centre_row_o   (centre_row_o),
    .frame_done_o   (frame_done_o)
  );

  // Frame size actually in use
  function automatic int unsigned eff_width(input logic [CfgW-1:0] w);
    int unsigned v;
    v = w;
    if (v < MinSize) v = MinSize;
    if (v > MaxW) v = MaxW;
    return v;
  endfunction

  function automatic int unsigned eff_height(input logic [CfgW-1:0] h);
    int unsigned v;
    v = h;
    if (v < MinSize) v = MinSize;
    return v;
  endfunction

  // Advance the predictor by one pixel; returns 1 when the pixel completes an interior window
  function automatic bit blur_window(input logic [PixW-1:0] pix, output blur_res_t res);
    int unsigned ew, eh, c, r, ci, sum, k;
    logic [PixW-1:0] top, mid;
    bit last_col, last_row, hit;
    ew = eff_width(cfg_width);
    eh = eff_height(cfg_height);
    c  = col_cnt;
    r  = row_cnt;
    ci = (c < MaxW) ? c : MaxW - 1;
    top = row_two_above[ci];
    mid = row_above[ci];
    last_col = (c + 1 >= ew);
    last_row = (r + 1 >= eh);
    hit = (c >= 2) && (r >= 2);
    res = '0;
    if (hit) begin
      sum = top + mid + pix;
      for (k = 0; k < 3; k++) sum += win_prev2[k] + win_prev1[k];
      res.mean = PixW'(sum / BlurDiv);
      res.col  = ColW'(c - 1);
      res.row  = RowW'(r - 1);
      res.done = last_col && last_row;
    end
    // shift the window, store the new column
    win_prev2 = win_prev1;
    win_prev1[0] = top;
    win_prev1[1] = mid;
    win_prev1[2] = pix;
    row_two_above[ci] = mid;
    row_above[ci]     = pix;
    // raster position; a wrap on the last row ends the frame
    if (last_col) begin
      col_cnt = '0;
      row_cnt = last_row ? '0 : RowW'(r + 1);
    end else begin
      col_cnt = ColW'(c + 1);
    end
    return hit;
  endfunction

  // Write both size registers on consecutive cycles
  task automatic write_size(input logic [CfgW-1:0] w, input logic [CfgW-1:0] h);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_IMAGE_WIDTH;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_width = w;
    cfg_idx_i   <= CFG_IMAGE_HEIGHT;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_height = h;
    cfg_we_i <= 1'b0;
  endtask

  // Wait for every expected result, then let border pixels leave the pipeline
  task automatic wait_drained();
    while (pending_blurs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Offer one pixel, optionally after an idle burst, and predict at acceptance
  task automatic send_pixel(input logic [PixW-1:0] pix, input bit typed,
                            input blur_res_t typed_res);
    blur_res_t res;
    bit hit;
    if (src_gaps && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_value_i <= pix;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    hit = blur_window(pix, res);
    if (typed) pending_blurs.push_back(typed_res);
    else if (hit) pending_blurs.push_back(res);
  endtask

  // Set the frame size while idle, then stream random pixels
  task automatic run_phase(input logic [CfgW-1:0] w, input logic [CfgW-1:0] h,
                           input int unsigned frames, input int unsigned extra,
                           output int unsigned sent);
    wait_drained();
    write_size(w, h);
    sent = frames * eff_width(w) * eff_height(h) + extra;
    repeat (sent) send_pixel(PixW'($urandom_range(0, 255)), 1'b0, '0);
    in_valid_i <= 1'b0;
  endtask

  // Result sink: stall bursts of random length
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 18);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Compare each accepted result transaction with the oldest expectation
  always @(posedge clk_i) begin : result_check
    blur_res_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{blurred_value_o, centre_column_o, centre_row_o, frame_done_o};
      if (pending_blurs.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        mismatches++;
      end else begin
        want = pending_blurs.pop_front();
        if (got.mean !== want.mean) begin
          $display("%0t: blurred_value expected %0d got %0d", $time, want.mean, got.mean);
          mismatches++;
        end
        if (got.col !== want.col) begin
          $display("%0t: centre_column expected %0d got %0d", $time, want.col, got.col);
          mismatches++;
        end
        if (got.row !== want.row) begin
          $display("%0t: centre_row expected %0d got %0d", $time, want.row, got.row);
          mismatches++;
        end
        if (got.done !== want.done) begin
          $display("%0t: frame_done expected %0d got %0d", $time, want.done, got.done);
          mismatches++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    logic [CfgW-1:0] w, h;
    int unsigned n, random_sent, ew, eh, frames, extra, room;
    bit quiet;

    for (int i = 0; i < MaxW; i++) begin
      row_above[i]     = '0;
      row_two_above[i] = '0;
    end
    for (int k = 0; k < 3; k++) begin
      win_prev2[k] = '0;
      win_prev1[k] = '0;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Smallest frame: all white, then ones with a single zero (8/9 truncates to 0)
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    write_size(12'd3, 12'd3);
    dir_table = '{
      '{8'd255, 1'b0, '0}, '{8'd255, 1'b0, '0}, '{8'd255, 1'b0, '0},
      '{8'd255, 1'b0, '0}, '{8'd255, 1'b0, '0}, '{8'd255, 1'b0, '0},
      '{8'd255, 1'b0, '0}, '{8'd255, 1'b0, '0},
      '{8'd255, 1'b1, '{8'd255, 11'd1, 12'd1, 1'b1}},
      '{8'd1, 1'b0, '0}, '{8'd1, 1'b0, '0}, '{8'd1, 1'b0, '0},
      '{8'd1, 1'b0, '0}, '{8'd1, 1'b0, '0}, '{8'd1, 1'b0, '0},
      '{8'd1, 1'b0, '0}, '{8'd1, 1'b0, '0},
      '{8'd0, 1'b1, '{8'd0, 11'd1, 12'd1, 1'b1}}
    };
    foreach (dir_table[i]) send_pixel(dir_table[i].pix, dir_table[i].typed, dir_table[i].res);
    in_valid_i <= 1'b0;

    // Size extremes: undersized registers, then one full row at the clamped widest width
    run_phase(12'd0, 12'd1, 2, 0, n);
    run_phase(12'd4095, 12'd0, 0, MaxW, n);
    // Narrow the frame at the start of row 1, stop inside row 2, then shrink the
    // width below the current column
    run_phase(12'd40, 12'd0, 0, 50, n);
    run_phase(12'd5, 12'd3, 1, 1, n);
    // Tallest height register: the first rows of a frame
    run_phase(12'd2, 12'd4095, 0, 60, n);

    // Random frame sizes, often changed in the middle of a frame
    random_sent = 0;
    while (random_sent < RandomPixels) begin
      quiet     = (random_sent + QuietTail >= RandomPixels);
      src_gaps  = !quiet && ($urandom_range(0, 3) != 0);
      sink_gaps = !quiet && ($urandom_range(0, 3) != 0);
      w = ($urandom_range(0, 7) == 0) ? CfgW'($urandom_range(0, 2))
                                      : CfgW'($urandom_range(3, 24));
      h = ($urandom_range(0, 7) == 0) ? CfgW'($urandom_range(0, 2))
                                      : CfgW'($urandom_range(3, 8));
      // mid-frame the width may only shrink, so no unwritten line-store entry is used
      if ((col_cnt != 0 || row_cnt != 0) && eff_width(w) > eff_width(cfg_width))
        w = cfg_width;
      ew     = eff_width(w);
      eh     = eff_height(h);
      frames = $urandom_range(0, 2);
      extra  = $urandom_range(0, ew * eh - 1);
      if (frames == 0 && extra == 0) extra = 1;
      // a phase with idling never runs into the quiet tail
      if (!quiet) begin
        room = RandomPixels - QuietTail - random_sent;
        if (frames * ew * eh + extra > room) begin
          frames = 0;
          extra  = room;
        end
      end
      run_phase(w, h, frames, extra, n);
      random_sent += n;
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("%0t: timeout, %0d results outstanding", $time, pending_blurs.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule : tb_box_blur_3x3_gray_unit

`default_nettype wire

// File: box_blur_3x3_gray_unit.f
rtl/bb3g_pkg.sv
rtl/bb3g_ram.sv
rtl/box_blur_3x3_gray_unit.sv
tb/sv/tb_box_blur_3x3_gray_unit.sv
